// ===== design/exlex_pkg.sv =====
// ----------------------------------------------------------------------------
// exlex_pkg
// Shared types, constants and character classification for the expression
// lexer.
// ----------------------------------------------------------------------------
package exlex_pkg;

    localparam int MAX_TOKENS = 128;
    localparam int MAX_TEXT   = 1024;

    localparam int POS_W   = $clog2(MAX_TEXT);
    localparam int FIELD_W = 10;
    localparam int TOK_W   = 8;
    localparam int CHAR_W  = 8;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam int TDATA_W = 32;
    localparam int TUSER_W = 2;

    localparam logic [POS_W-1:0] POS_LAST   = POS_W'(MAX_TEXT - 1);
    localparam logic [TOK_W-1:0] TOK_LIMIT  = TOK_W'(MAX_TOKENS);

    localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
    localparam logic [CHAR_W-1:0] CH_LOW_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOW_Z  = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_UP_A   = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_Z   = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
    localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_EQUAL  = 8'h3D;
    localparam logic [CHAR_W-1:0] CH_HASH   = 8'h23;
    localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;

    typedef enum logic [1:0] {
        CLS_OTHER  = 2'd0,
        CLS_LETTER = 2'd1,
        CLS_DIGIT  = 2'd2,
        CLS_OPER   = 2'd3
    } t_cls;

    typedef enum logic [1:0] {
        KIND_IDENT  = 2'd0,
        KIND_NUMBER = 2'd1,
        KIND_OPER   = 2'd2,
        KIND_END    = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [FIELD_W-1:0] start;
        logic [FIELD_W-1:0] len;
        logic [TOK_W-1:0]   index;
        logic               ovf;
        logic               last;
    } t_result;

    typedef struct packed {
        logic    a_valid;
        t_result a;
        logic    b_valid;
        t_result b;
    } t_push;

    function automatic t_cls classify(input logic [CHAR_W-1:0] c);
        t_cls cls;
        if ((c >= CH_LOW_A && c <= CH_LOW_Z) || (c >= CH_UP_A && c <= CH_UP_Z)) begin
            cls = CLS_LETTER;
        end else if (c >= CH_ZERO && c <= CH_NINE) begin
            cls = CLS_DIGIT;
        end else if (c == CH_STAR || c == CH_SLASH || c == CH_PLUS || c == CH_MINUS ||
                     c == CH_EQUAL || c == CH_HASH || c == CH_LPAREN || c == CH_RPAREN) begin
            cls = CLS_OPER;
        end else begin
            cls = CLS_OTHER;
        end
        return cls;
    endfunction

endpackage

// ===== design/exlex_core.sv =====
// ----------------------------------------------------------------------------
// exlex_core
// Input register and single-pass classification: updates the run state and
// produces up to two result records per character.
// ----------------------------------------------------------------------------
module exlex_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [exlex_pkg::CHAR_W-1:0]  i_char,
    input  logic                          i_room,
    output exlex_pkg::t_push              o_push
);
    import exlex_pkg::*;

    logic              r_valid;
    logic [CHAR_W-1:0] r_char;
    t_cls              r_run_kind;
    logic [POS_W-1:0]  r_run_start;
    logic [POS_W-1:0]  r_run_len;
    logic [POS_W-1:0]  r_pos;
    logic [TOK_W-1:0]  r_total;
    logic              r_ovf;

    t_cls              n_run_kind;
    logic [POS_W-1:0]  n_run_start;
    logic [POS_W-1:0]  n_run_len;
    logic [POS_W-1:0]  n_pos;
    logic [TOK_W-1:0]  n_total;
    logic              n_ovf;

    logic              advance;
    t_cls              cls;
    logic              is_nul;
    logic              extend;
    logic              flush_a;
    logic              emit_b;
    logic              a_full;
    logic [TOK_W-1:0]  total_a;
    logic              ovf_a;
    logic              b_full;
    logic [POS_W-1:0]  pos_inc;

    assign advance = r_valid && i_room;
    assign o_ready = !r_valid || i_room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_char <= i_char;
        end
    end

    always_comb begin
        cls     = classify(r_char);
        is_nul  = (r_char == CH_NUL);
        extend  = !is_nul && (r_run_kind != CLS_OTHER) && (r_run_kind == cls);
        flush_a = !extend && (r_run_kind != CLS_OTHER);
        emit_b  = !extend && (is_nul || cls == CLS_OPER);
        pos_inc = (r_pos == POS_LAST) ? '0 : r_pos + 1'b1;

        a_full  = (r_total >= TOK_LIMIT);
        total_a = (flush_a && !a_full) ? r_total + 1'b1 : r_total;
        ovf_a   = r_ovf || (flush_a && a_full);
        b_full  = (total_a >= TOK_LIMIT);

        o_push.a_valid = advance && flush_a;
        o_push.a.kind  = (r_run_kind == CLS_LETTER) ? KIND_IDENT : KIND_NUMBER;
        o_push.a.start = FIELD_W'(r_run_start);
        o_push.a.len   = FIELD_W'(r_run_len);
        o_push.a.index = a_full ? TOK_LIMIT : r_total;
        o_push.a.ovf   = a_full;
        o_push.a.last  = !emit_b;

        o_push.b_valid = advance && emit_b;
        o_push.b.start = FIELD_W'(r_pos);
        o_push.b.last  = 1'b1;
        if (is_nul) begin
            o_push.b.kind  = KIND_END;
            o_push.b.len   = '0;
            o_push.b.index = total_a;
            o_push.b.ovf   = ovf_a;
        end else begin
            o_push.b.kind  = KIND_OPER;
            o_push.b.len   = FIELD_W'(1);
            o_push.b.index = b_full ? TOK_LIMIT : total_a;
            o_push.b.ovf   = b_full;
        end

        n_run_kind  = r_run_kind;
        n_run_start = r_run_start;
        n_run_len   = r_run_len;
        n_pos       = r_pos;
        n_total     = r_total;
        n_ovf       = r_ovf;
        if (is_nul) begin
            n_run_kind  = CLS_OTHER;
            n_run_start = '0;
            n_run_len   = '0;
            n_pos       = '0;
            n_total     = '0;
            n_ovf       = 1'b0;
        end else if (extend) begin
            n_run_len = (r_run_len == POS_LAST) ? r_run_len : r_run_len + 1'b1;
            n_pos     = pos_inc;
        end else begin
            n_pos   = pos_inc;
            n_total = (cls == CLS_OPER && !b_full) ? total_a + 1'b1 : total_a;
            n_ovf   = ovf_a || (cls == CLS_OPER && b_full);
            if (cls == CLS_LETTER || cls == CLS_DIGIT) begin
                n_run_kind  = cls;
                n_run_start = r_pos;
                n_run_len   = POS_W'(1);
            end else begin
                n_run_kind  = CLS_OTHER;
                n_run_start = '0;
                n_run_len   = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_kind  <= CLS_OTHER;
            r_run_start <= '0;
            r_run_len   <= '0;
            r_pos       <= '0;
            r_total     <= '0;
            r_ovf       <= 1'b0;
        end else if (advance) begin
            r_run_kind  <= n_run_kind;
            r_run_start <= n_run_start;
            r_run_len   <= n_run_len;
            r_pos       <= n_pos;
            r_total     <= n_total;
            r_ovf       <= n_ovf;
        end
    end

endmodule

// ===== design/exlex_queue.sv =====
// ----------------------------------------------------------------------------
// exlex_queue
// Small result queue: takes up to two records per cycle, hands out one per
// transaction on the output stream.
// ----------------------------------------------------------------------------
module exlex_queue (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  exlex_pkg::t_push                    i_push,
    output logic                                o_room,
    output logic                                o_valid,
    input  logic                                i_ready,
    output exlex_pkg::t_result                  o_result
);
    import exlex_pkg::*;

    t_result            r_slot [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wptr;
    logic [Q_PTR_W-1:0] r_rptr;
    logic [Q_CNT_W-1:0] r_count;

    logic               pop;
    logic [Q_PTR_W-1:0] b_addr;
    logic [1:0]         n_push;

    assign o_valid  = (r_count != '0);
    assign o_result = r_slot[r_rptr];
    assign o_room   = (r_count <= Q_CNT_W'(Q_DEPTH - 2));
    assign pop      = o_valid && i_ready;
    assign b_addr   = i_push.a_valid ? r_wptr + 1'b1 : r_wptr;
    assign n_push   = {1'b0, i_push.a_valid} + {1'b0, i_push.b_valid};

    always_ff @(posedge i_clk) begin
        if (i_push.a_valid) begin
            r_slot[r_wptr] <= i_push.a;
        end
        if (i_push.b_valid) begin
            r_slot[b_addr] <= i_push.b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= r_wptr + Q_PTR_W'(n_push);
            r_rptr  <= r_rptr + Q_PTR_W'(pop);
            r_count <= r_count + Q_CNT_W'(n_push) - Q_CNT_W'(pop);
        end
    end

endmodule

// ===== design/expression_lexer.sv =====
// ----------------------------------------------------------------------------
// expression_lexer
// Splits a byte stream into identifier, number and operator tokens and
// closes each zero-terminated string with an end record.
// ----------------------------------------------------------------------------
//  channel  | dir | transaction
//  ---------+-----+--------------------------------------------------------
//  s_axis   | in  | one text byte, zero ends the string
//  m_axis   | out | one token or end record; tlast on the last one per byte
//
//  One byte per cycle while the result queue has room; a byte yields zero, one or two records.
//  A byte passes through the input register and then the result queue.
//  A byte that yields two records hands them out as two output transactions.
//  Four-entry result queue; input stalls while fewer than two slots are free.
//  Synchronous active-low reset clears the run state and the queue.
// ----------------------------------------------------------------------------
module expression_lexer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [exlex_pkg::CHAR_W-1:0]     s_axis_tdata,  // [7:0] char_code
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [9:0] token_start, [19:10] token_len, [27:20] token_index, [28] overflow
    output logic [exlex_pkg::TDATA_W-1:0]    m_axis_tdata,
    output logic [exlex_pkg::TUSER_W-1:0]    m_axis_tuser,  // [1:0] token_kind
    output logic                             m_axis_tlast   // last_result
);
    import exlex_pkg::*;

    t_push   push;
    logic    room;
    t_result result;

    exlex_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_char  (s_axis_tdata),
        .i_room  (room),
        .o_push  (push)
    );

    exlex_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_room   (room),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (result)
    );

    assign m_axis_tdata = TDATA_W'({result.ovf, result.index, result.len, result.start});
    assign m_axis_tuser = result.kind;
    assign m_axis_tlast = result.last;

endmodule

// ===== design/exlex_checker.sv =====
// ----------------------------------------------------------------------------
// exlex_checker
// Port-level checks on the token stream, bound to expression_lexer.
// ----------------------------------------------------------------------------
module exlex_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [exlex_pkg::TDATA_W-1:0]  m_axis_tdata,
    input logic [exlex_pkg::TUSER_W-1:0]  m_axis_tuser,
    input logic                           m_axis_tlast
);
    import exlex_pkg::*;

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled record changed");

    a_end_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_END |->
            m_axis_tlast && m_axis_tdata[19:10] == 10'd0)
        else $error("end record malformed");

    a_oper_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_OPER |->
            m_axis_tlast && m_axis_tdata[19:10] == 10'd1)
        else $error("operator record malformed");

    a_overflow_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != KIND_END && m_axis_tdata[28] |->
            m_axis_tdata[27:20] == TOK_LIMIT)
        else $error("overflow token with wrong index");

endmodule

bind expression_lexer exlex_checker u_exlex_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== dv/expression_lexer_tb.sv =====
// ----------------------------------------------------------------------------
// expression_lexer_tb
// Streams text bytes into the lexer and checks every token and end record
// against a cycle-free model of the tokenizer kept in the bench. Covers
// directed corner cases, token table overflow, position wrap with run length
// saturation, and random strings under random stalls on both sides.
// ----------------------------------------------------------------------------
module expression_lexer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import exlex_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int QUIET_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 10;
    localparam int RANDOM_ITEMS = 300;
    localparam int PREFIX_CHARS = 530;
    localparam int LONG_RUN     = 1030;

    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [CHAR_W-1:0] OPER_CHARS [8] = '{
        CH_STAR, CH_SLASH, CH_PLUS, CH_MINUS, CH_EQUAL, CH_HASH, CH_LPAREN, CH_RPAREN
    };

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [CHAR_W-1:0]    s_axis_tdata;   // [7:0] char_code
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    // [9:0] token_start, [19:10] token_len, [27:20] token_index, [28] overflow
    logic [TDATA_W-1:0]   m_axis_tdata;
    logic [TUSER_W-1:0]   m_axis_tuser;   // [1:0] token_kind
    logic                 m_axis_tlast;   // last_result

    t_result pending_tokens[$];
    int      mismatch_count;
    int      quiet_cycles;
    int      rx_hold;
    bit      tx_idle_en;
    bit      rx_idle_en;

    t_cls    run_cls;
    int      run_begin;
    int      run_count;
    int      text_pos;
    int      tok_count;
    logic    tbl_over;

    expression_lexer i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return $urandom_range(1, 3);
        end
        if (r < 95) begin
            return $urandom_range(4, 8);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic t_cls char_class(input logic [CHAR_W-1:0] c);
        if ((c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LOW_A && c <= CH_LOW_Z)) begin
            return CLS_LETTER;
        end
        if (c >= CH_ZERO && c <= CH_NINE) begin
            return CLS_DIGIT;
        end
        foreach (OPER_CHARS[i]) begin
            if (c == OPER_CHARS[i]) begin
                return CLS_OPER;
            end
        end
        return CLS_OTHER;
    endfunction

    function automatic t_result make_rec(t_kind k, int start, int len, int index, logic ovf);
        t_result r;
        r.kind  = k;
        r.start = FIELD_W'(start);
        r.len   = FIELD_W'(len);
        r.index = TOK_W'(index);
        r.ovf   = ovf;
        r.last  = 1'b0;
        return r;
    endfunction

    function automatic t_result count_token(t_kind k, int start, int len);
        if (tok_count < MAX_TOKENS) begin
            tok_count++;
            return make_rec(k, start, len, tok_count - 1, 1'b0);
        end
        tbl_over = 1'b1;
        return make_rec(k, start, len, MAX_TOKENS, 1'b1);
    endfunction

    function automatic void clear_lexer();
        run_cls   = CLS_OTHER;
        run_begin = 0;
        run_count = 0;
        text_pos  = 0;
        tok_count = 0;
        tbl_over  = 1'b0;
    endfunction

    function automatic void lex_char(input logic [CHAR_W-1:0] c);
        t_cls    cls;
        t_result recs [2];
        int      n;
        cls = char_class(c);
        n   = 0;
        // extend the pending run
        if (c != CH_NUL && run_cls != CLS_OTHER && run_cls == cls) begin
            if (run_count < MAX_TEXT - 1) begin
                run_count++;
            end
            text_pos = (text_pos + 1) % MAX_TEXT;
            return;
        end
        if (run_cls != CLS_OTHER) begin
            recs[n] = count_token(run_cls == CLS_LETTER ? KIND_IDENT : KIND_NUMBER,
                                  run_begin, run_count);
            n++;
            run_cls   = CLS_OTHER;
            run_begin = 0;
            run_count = 0;
        end
        if (c == CH_NUL) begin
            recs[n] = make_rec(KIND_END, text_pos, 0, tok_count, tbl_over);
            n++;
            clear_lexer();
        end else begin
            if (cls == CLS_LETTER || cls == CLS_DIGIT) begin
                run_cls   = cls;
                run_begin = text_pos;
                run_count = 1;
            end else if (cls == CLS_OPER) begin
                recs[n] = count_token(KIND_OPER, text_pos, 1);
                n++;
            end
            text_pos = (text_pos + 1) % MAX_TEXT;
        end
        if (n > 0) begin
            recs[n - 1].last = 1'b1;
        end
        for (int i = 0; i < n; i++) begin
            pending_tokens.push_back(recs[i]);
        end
    endfunction

    function automatic string fmt_rec(t_result r);
        return $sformatf("kind=%0d start=%0d len=%0d index=%0d ovf=%0b last=%0b",
                         r.kind, r.start, r.len, r.index, r.ovf, r.last);
    endfunction

    function automatic void note_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("[%0t] %s", $time, msg);
        end
    endfunction

    function automatic logic [CHAR_W-1:0] rand_letter();
        if ($urandom_range(0, 1) == 0) begin
            return CH_LOW_A + CHAR_W'($urandom_range(0, 25));
        end
        return CH_UP_A + CHAR_W'($urandom_range(0, 25));
    endfunction

    function automatic logic [CHAR_W-1:0] rand_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) begin
            return rand_letter();
        end
        if (r < 60) begin
            return CH_ZERO + CHAR_W'($urandom_range(0, 9));
        end
        if (r < 78) begin
            return OPER_CHARS[$urandom_range(0, 7)];
        end
        if (r < 86) begin
            return CH_SPACE;
        end
        if (r < 90) begin
            return CH_NEWLINE;
        end
        return CHAR_W'($urandom_range(1, 255));
    endfunction

    // check each result transaction against the oldest expected token
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.kind  = t_kind'(m_axis_tuser);
            got.start = m_axis_tdata[9:0];
            got.len   = m_axis_tdata[19:10];
            got.index = m_axis_tdata[27:20];
            got.ovf   = m_axis_tdata[28];
            got.last  = m_axis_tlast;
            if (pending_tokens.size() == 0) begin
                note_mismatch({"unexpected token: ", fmt_rec(got)});
            end else begin
                want = pending_tokens.pop_front();
                if (got.kind !== want.kind || got.start !== want.start ||
                    got.len !== want.len || got.index !== want.index ||
                    got.ovf !== want.ovf || got.last !== want.last) begin
                    note_mismatch({"token mismatch: expected ", fmt_rec(want),
                                   " got ", fmt_rec(got)});
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            m_axis_tready <= 1'b0;
            rx_hold--;
        end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
            m_axis_tready <= 1'b0;
            rx_hold = pick_gap() - 1;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic send_char(input logic [CHAR_W-1:0] c);
        int gap;
        gap = (tx_idle_en && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        do @(posedge i_clk); while (!s_axis_tready);
        lex_char(c);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_char(s[i]);
        end
    endtask

    // hold input until every expected token has come out
    task automatic drain_tokens();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_tokens.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_directed();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        send_text("aZ09z1A*/+-=#()");
        send_char(CH_SPACE);
        send_char(8'hFF);
        send_char(CH_NINE);
        send_char(CH_NEWLINE);
        send_text("q");
        send_char(CH_NUL);
        send_char(CH_NUL);
        send_text("7");
        send_char(CH_NUL);
    endtask

    task automatic test_table_full();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b1;
        for (int i = 0; i < 70; i++) begin
            send_char(rand_letter());
            send_char(OPER_CHARS[$urandom_range(0, 7)]);
        end
        send_text("x1");
        send_char(CH_NUL);
    endtask

    task automatic test_long_text();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        for (int i = 0; i < PREFIX_CHARS; i++) begin
            send_char(rand_char());
        end
        send_char(CH_SPACE);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        for (int i = 0; i < LONG_RUN; i++) begin
            send_char(rand_letter());
        end
        send_text("77-");
        send_char(CH_NUL);
    endtask

    task automatic test_random();
        int sent;
        int len;
        int r;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            tx_idle_en = $urandom_range(0, 3) != 0;
            rx_idle_en = $urandom_range(0, 3) != 0;
            r = $urandom_range(0, 99);
            len = (r < 92) ? $urandom_range(1, 30) : $urandom_range(60, 120);
            for (int i = 0; i < len; i++) begin
                // cut the string short now and then
                send_char($urandom_range(0, 99) < 3 ? CH_NUL : rand_char());
            end
            send_char(CH_NUL);
            sent += len + 1;
            if ($urandom_range(0, 7) == 0) begin
                drain_tokens();
            end
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        m_axis_tready  = 1'b0;
        tx_idle_en     = 1'b0;
        rx_idle_en     = 1'b0;
        mismatch_count = 0;
        quiet_cycles   = 0;
        rx_hold        = 0;
        clear_lexer();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        drain_tokens();
        test_table_full();
        drain_tokens();
        test_long_text();
        test_random();
        drain_tokens();

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
